### hw/rtl/cerd_pkg.sv
// Package for the chatter energy ratio detector.
// Holds widths, ratio constants, register indexes and the sequencer state type.
// No dependencies.
`default_nettype none

package cerd_pkg;

   localparam int ENERGY_WIDTH        = 32;
   localparam int RATIO_WIDTH         = 17;
   localparam int CSR_INDEX_WIDTH     = 2;
   localparam int CSR_DATA_WIDTH      = 32;
   localparam int DELAY_DEPTH_DEFAULT = 8;

   // one quotient bit per step, quotient spans 0..65536
   localparam int DIV_STEPS = RATIO_WIDTH;
   localparam int CNT_WIDTH = $clog2(DIV_STEPS);

   localparam logic [RATIO_WIDTH-1:0] RATIO_HALF  = 17'd32768;
   localparam logic [RATIO_WIDTH-1:0] RATIO_TENTH = 17'd6554;
   localparam logic [RATIO_WIDTH-1:0] RATIO_ONE   = 17'd65536;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ENERGY_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RATIO_LIMIT      = 2'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/chatter_energy_ratio_detector.sv
// Chatter energy ratio detector: delay line memory, restoring divider, decision.
// Depends on cerd_pkg.
// From input transfer to result valid the sequencer runs divider setup, 17
// divider steps of one quotient bit each, and the decision; the memory read rides
// the transfer edge. One item is handled at a time, paced by the bit-serial
// divider; a new one waits longer while a finished result waits for the result
// register to free up. A new item is taken as soon as the sequencer is idle,
// even while a result waits.
// Reset clears control state and config; datapath registers and the memory are
// not swept: entries not yet written since reset read as zero via a wrap flag.
`default_nettype none

module chatter_energy_ratio_detector #(
   parameter int DELAY_DEPTH = cerd_pkg::DELAY_DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [cerd_pkg::ENERGY_WIDTH-1:0]    req_chatter_energy,
   input  wire logic [cerd_pkg::ENERGY_WIDTH-1:0]    req_periodic_energy,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_detected,
   output logic [cerd_pkg::RATIO_WIDTH-1:0]          rsp_energy_ratio,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [cerd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [cerd_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int EW    = cerd_pkg::ENERGY_WIDTH;
   localparam int RW    = cerd_pkg::RATIO_WIDTH;
   localparam int PTR_W = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DELAY_DEPTH - 1);

   cerd_pkg::state_type state_ff, state_in;

   logic [EW-1:0] energy_threshold_ff;
   logic [RW-1:0] ratio_limit_ff;

   logic [EW-1:0] delay_mem [DELAY_DEPTH];
   logic [EW-1:0] mem_rdata_ff;
   logic [PTR_W-1:0] wptr_ff;
   logic             wrapped_ff;
   logic             old_valid_ff;

   logic [EW-1:0] chat_ff;
   logic [EW-1:0] per_ff;
   logic [EW:0]   divisor_ff;
   logic [EW:0]   rem_ff;
   logic [RW-1:0] nbits_ff;
   logic [RW-1:0] quot_ff;
   logic [cerd_pkg::CNT_WIDTH-1:0] cnt_ff;
   logic          zero_ff;
   logic          prev_flag_ff;

   logic          rsp_valid_ff;
   logic          rsp_detected_ff;
   logic [RW-1:0] rsp_ratio_ff;

   logic          req_xfer;
   logic          out_free;
   logic          div_last;
   logic [EW-1:0] oldest;
   logic [EW+1:0] rem_sh;
   logic [EW+2:0] trial;
   logic [RW-1:0] ratio;
   logic          flag;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cerd_pkg::ST_IDLE:   if (req_xfer) state_in = cerd_pkg::ST_LOAD;
         cerd_pkg::ST_LOAD:   state_in = cerd_pkg::ST_DIV;
         cerd_pkg::ST_DIV:    if (div_last) state_in = cerd_pkg::ST_FINISH;
         cerd_pkg::ST_FINISH: if (out_free) state_in = cerd_pkg::ST_IDLE;
         default:             state_in = cerd_pkg::ST_IDLE;
      endcase
   end

   // ---------------- outputs ----------------
   always_comb begin
      req_ready        = (state_ff == cerd_pkg::ST_IDLE);
      csr_ready        = 1'b1;
      rsp_valid        = rsp_valid_ff;
      rsp_detected     = rsp_detected_ff;
      rsp_energy_ratio = rsp_ratio_ff;
   end

   // ---------------- datapath logic ----------------
   always_comb begin
      req_xfer = req_valid && req_ready;
      out_free = !rsp_valid_ff || rsp_ready;
      div_last = (cnt_ff == cerd_pkg::CNT_WIDTH'(cerd_pkg::DIV_STEPS - 1));
      oldest   = old_valid_ff ? mem_rdata_ff : '0;

      rem_sh = {rem_ff, nbits_ff[RW-1]};
      trial  = {1'b0, rem_sh} - {2'b00, divisor_ff};

      ratio = zero_ff ? '0 : quot_ff;
      if (!prev_flag_ff && ratio > cerd_pkg::RATIO_HALF) begin
         flag = 1'b0;   // entry rule: a strong ratio blocks a new detection
      end else if (prev_flag_ff && ratio > cerd_pkg::RATIO_TENTH) begin
         flag = 1'b1;
      end else if (ratio > ratio_limit_ff && per_ff > energy_threshold_ff) begin
         flag = 1'b1;
      end else begin
         flag = 1'b0;
      end
   end

   // ---------------- delay line memory ----------------
   // Circular buffer: entry at wptr is the oldest; read first, then overwrite.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         mem_rdata_ff       <= delay_mem[wptr_ff];
         delay_mem[wptr_ff] <= req_periodic_energy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff    <= '0;
         wrapped_ff <= 1'b0;
      end else if (req_xfer) begin
         if (wptr_ff == PTR_LAST) begin
            wptr_ff    <= '0;
            wrapped_ff <= 1'b1;
         end else begin
            wptr_ff <= wptr_ff + 1'b1;
         end
      end
   end

   // ---------------- sequencer and divider ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cerd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         cerd_pkg::ST_IDLE: begin
            if (req_xfer) begin
               chat_ff      <= req_chatter_energy;
               per_ff       <= req_periodic_energy;
               old_valid_ff <= wrapped_ff;
            end
         end
         cerd_pkg::ST_LOAD: begin
            divisor_ff <= {1'b0, chat_ff} + {1'b0, oldest};
            zero_ff    <= (chat_ff == '0) && (oldest == '0);
            // quotient fits in 17 bits, so start with the top dividend bits
            rem_ff     <= {2'b00, chat_ff[EW-1:1]};
            nbits_ff   <= {chat_ff[0], {(RW-1){1'b0}}};
            quot_ff    <= '0;
            cnt_ff     <= '0;
         end
         cerd_pkg::ST_DIV: begin
            if (!trial[EW+2]) begin
               rem_ff <= trial[EW:0];
            end else begin
               rem_ff <= rem_sh[EW:0];
            end
            quot_ff  <= {quot_ff[RW-2:0], !trial[EW+2]};
            nbits_ff <= {nbits_ff[RW-2:0], 1'b0};
            cnt_ff   <= cnt_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // ---------------- result register and flag ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         prev_flag_ff <= 1'b0;
      end else if (state_ff == cerd_pkg::ST_FINISH && out_free) begin
         rsp_valid_ff <= 1'b1;
         prev_flag_ff <= flag;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == cerd_pkg::ST_FINISH && out_free) begin
         rsp_detected_ff <= flag;
         rsp_ratio_ff    <= ratio;
      end
   end

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         energy_threshold_ff <= '0;
         ratio_limit_ff      <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cerd_pkg::CSR_ENERGY_THRESHOLD: energy_threshold_ff <= csr_wdata;
            cerd_pkg::CSR_RATIO_LIMIT:      ratio_limit_ff <= csr_wdata[RW-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------- assertions ----------------
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == cerd_pkg::ST_FINISH))
      else $error("result appeared without a finished division");

   a_ratio_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_energy_ratio <= cerd_pkg::RATIO_ONE))
      else $error("energy ratio above one");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cerd_pkg::ST_DIV) |->
         (cnt_ff < cerd_pkg::CNT_WIDTH'(cerd_pkg::DIV_STEPS)))
      else $error("divider step count overran");

   a_load_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == cerd_pkg::ST_LOAD))
      else $error("input transfer did not start a division");

endmodule

`default_nettype wire
